// ----- hdl/tss_pkg.sv -----
package tss_pkg;

	localparam int NUM_ROWS = 3;

	// row and place codes inside one scan run
	localparam logic [1:0] ROW_TOP    = 2'd0;
	localparam logic [1:0] ROW_MIDDLE = 2'd1;
	localparam logic [1:0] ROW_BOTTOM = 2'd2;

	localparam logic [1:0] PLACE_ONES = 2'd0;
	localparam logic [1:0] PLACE_TENS = 2'd1;
	localparam logic [1:0] PLACE_HUND = 2'd2;
	localparam logic [1:0] PLACE_THOU = 2'd3;

	// reciprocals for the constant divides, floor(v*m >> k)
	localparam logic [16:0] RECIP_1000 = 17'd67109;  // k = 26, v < 65536
	localparam logic [5:0]  RECIP_100  = 6'd41;      // k = 12, v < 1000
	localparam logic [7:0]  RECIP_10   = 8'd205;     // k = 11, v < 100

	localparam logic [9:0] DEC_1000 = 10'd1000;
	localparam logic [6:0] DEC_100  = 7'd100;
	localparam logic [3:0] DEC_10   = 4'd10;

	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [7:0] SEG_POINT = 8'h80;
	localparam logic [7:0] SEG_ZERO  = 8'hC0;

	localparam logic [7:0] SEG_TABLE [16] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
	};

	typedef struct packed {
		logic [15:0] top_value;
		logic [15:0] middle_value;
		logic [15:0] bottom_value;
	} num_t;

	typedef struct packed {
		logic [7:0] segments;
		logic [7:0] select_first_bank;
		logic [7:0] select_second_bank;
		logic [3:0] digit_position;
		logic       last_digit;
	} scan_t;

	// decimal digits of one row
	typedef struct packed {
		logic [6:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} dig_row_t;

	typedef dig_row_t [NUM_ROWS-1:0] dig_item_t;

	// active-low pattern, anything past the hex range shows zero
	function automatic logic [7:0] seg_of(logic [6:0] d);
		logic [7:0] s;
		if (d > 7'd15) begin
			s = SEG_ZERO;
		end else begin
			s = SEG_TABLE[d[3:0]];
		end
		return s;
	endfunction

endpackage

// ----- hdl/tss_split.sv -----
module tss_split import tss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      num_valid,
	output logic      num_stall,
	input  num_t      num,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic [15:0] row_val [NUM_ROWS];

	// a stage moves when it is empty or the next one moves
	assign adv6 = !vld_s6 || !dig_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign num_stall = !adv1;
	assign dig_valid = vld_s6;

	assign row_val[0] = num.top_value;
	assign row_val[1] = num.middle_value;
	assign row_val[2] = num.bottom_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= num_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		logic [15:0] v_s1;
		logic [32:0] p1000_s1;
		logic [6:0]  thou_s2, thou_s3, thou_s4, thou_s5, thou_s6;
		logic [9:0]  rem_s2, rem_s3;
		logic [15:0] p100_s3;
		logic [3:0]  hund_s4, hund_s5, hund_s6;
		logic [6:0]  r100_s4, r100_s5;
		logic [14:0] p10_s5;
		logic [3:0]  tens_s6, ones_s6;
		logic [6:0]  thou_c;
		logic [16:0] t1000_c;
		logic [3:0]  hund_c;
		logic [9:0]  h100_c;
		logic [3:0]  tens_c;
		logic [6:0]  t10_c;

		assign thou_c  = p1000_s1[32:26];
		assign t1000_c = 17'(thou_c) * 17'(DEC_1000);
		assign hund_c  = p100_s3[15:12];
		assign h100_c  = 10'(hund_c) * 10'(DEC_100);
		assign tens_c  = p10_s5[14:11];
		assign t10_c   = 7'(tens_c) * 7'(DEC_10);

		always_ff @(posedge clk) begin
			if (adv1) begin
				v_s1     <= row_val[r];
				p1000_s1 <= 33'(row_val[r]) * 33'(RECIP_1000);
			end
			if (adv2) begin
				thou_s2 <= thou_c;
				rem_s2  <= 10'(v_s1 - t1000_c[15:0]);
			end
			if (adv3) begin
				thou_s3 <= thou_s2;
				rem_s3  <= rem_s2;
				p100_s3 <= 16'(rem_s2) * 16'(RECIP_100);
			end
			if (adv4) begin
				thou_s4 <= thou_s3;
				hund_s4 <= hund_c;
				r100_s4 <= 7'(rem_s3 - h100_c);
			end
			if (adv5) begin
				thou_s5 <= thou_s4;
				hund_s5 <= hund_s4;
				r100_s5 <= r100_s4;
				p10_s5  <= 15'(r100_s4) * 15'(RECIP_10);
			end
			if (adv6) begin
				thou_s6 <= thou_s5;
				hund_s6 <= hund_s5;
				tens_s6 <= tens_c;
				ones_s6 <= 4'(r100_s5 - t10_c);
			end
		end

		assign dig[r] = '{thou: thou_s6, hund: hund_s6, tens: tens_s6, ones: ones_s6};
	end

	// reciprocal slips would show up as digits out of range
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (dig[0].thou <= 7'd65 && dig[1].thou <= 7'd65 && dig[2].thou <= 7'd65
			&& dig[0].hund <= 4'd9 && dig[1].hund <= 4'd9 && dig[2].hund <= 4'd9
			&& dig[0].tens <= 4'd9 && dig[1].tens <= 4'd9 && dig[2].tens <= 4'd9
			&& dig[0].ones <= 4'd9 && dig[1].ones <= 4'd9 && dig[2].ones <= 4'd9))
		else $error("decimal digit out of range");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !adv5) |=> vld_s5)
		else $error("stage five dropped a stalled item");

endmodule

// ----- hdl/tss_scan.sv -----
module tss_scan import tss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dig_valid,
	output logic      dig_stall,
	input  dig_item_t dig,
	output logic      scan_valid,
	input  logic      scan_stall,
	output scan_t     scan
);

	dig_item_t  buf_q;
	logic       busy_q;
	logic [1:0] row_q;
	logic [1:0] place_q;
	logic       scan_valid_q;
	scan_t      scan_q;

	logic       load;
	logic       end_beat;
	logic       dig_take;
	dig_row_t   cur;
	logic [6:0] digit;
	logic [7:0] seg;
	logic [3:0] pos;
	logic [3:0] pos_idx;
	scan_t      beat;

	assign load     = busy_q && (!scan_valid_q || !scan_stall);
	assign end_beat = (row_q == ROW_BOTTOM) && (place_q == PLACE_THOU);
	// the buffer frees as its final beat moves out
	assign dig_stall = busy_q && !(load && end_beat);
	assign dig_take  = dig_valid && !dig_stall;

	assign cur = buf_q[row_q];

	always_comb begin
		case (place_q)
			PLACE_ONES: digit = 7'(cur.ones);
			PLACE_TENS: digit = 7'(cur.tens);
			PLACE_HUND: digit = 7'(cur.hund);
			PLACE_THOU: digit = cur.thou;
			default:    digit = 7'd0;
		endcase
	end

	always_comb begin
		seg = seg_of(digit);
		if (place_q == PLACE_THOU) begin
			seg = seg & ~SEG_POINT;
			if (row_q == ROW_TOP && cur.thou == 7'd0) begin
				seg = SEG_BLANK;
			end
		end
	end

	assign pos     = 4'({row_q, 2'b00}) + 4'(3'd4 - 3'(place_q));
	assign pos_idx = pos - 4'd1;

	always_comb begin
		beat.segments       = seg;
		beat.digit_position = pos;
		beat.last_digit     = end_beat;
		if (!pos_idx[3]) begin
			beat.select_first_bank  = ~(8'd1 << pos_idx[2:0]);
			beat.select_second_bank = 8'hFF;
		end else begin
			beat.select_first_bank  = 8'hFF;
			beat.select_second_bank = ~(8'd1 << pos_idx[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			row_q        <= ROW_TOP;
			place_q      <= PLACE_ONES;
			scan_valid_q <= 1'b0;
		end else begin
			if (dig_take) begin
				busy_q  <= 1'b1;
				row_q   <= ROW_TOP;
				place_q <= PLACE_ONES;
			end else if (load) begin
				if (end_beat) begin
					busy_q <= 1'b0;
				end else if (place_q == PLACE_THOU) begin
					place_q <= PLACE_ONES;
					row_q   <= row_q + 2'd1;
				end else begin
					place_q <= place_q + 2'd1;
				end
			end
			if (load) begin
				scan_valid_q <= 1'b1;
			end else if (!scan_stall) begin
				scan_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_take) buf_q <= dig;
		if (load) scan_q <= beat;
	end

	assign scan_valid = scan_valid_q;
	assign scan       = scan_q;

	a_one_select: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid_q |-> $countones({~scan_q.select_second_bank[3:0],
			~scan_q.select_first_bank}) == 1)
		else $error("not exactly one digit selected");

	a_last_is_nine: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid_q && scan_q.last_digit) |-> scan_q.digit_position == 4'd9)
		else $error("run closed on the wrong digit");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && end_beat && !dig_take) |=> !busy_q)
		else $error("scan run did not finish after its final beat");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (row_q == ROW_TOP || row_q == ROW_MIDDLE || row_q == ROW_BOTTOM))
		else $error("row counter past bottom row");

endmodule

// ----- hdl/three_row_seven_segment_scanner.sv -----
// three_row_seven_segment_scanner: three 16-bit numbers in, twelve digit scan beats out
// path: an input passes through six split stages, one run buffer and one output register
// rate: twelve beats per input, one beat a cycle while scan_stall is low, set by the serialiser
// reset: arst_n asynchronous, active low; clears all valid flags and the scan run
module three_row_seven_segment_scanner import tss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  num_valid,
	output logic  num_stall,
	input  num_t  num,
	output logic  scan_valid,
	input  logic  scan_stall,
	output scan_t scan
);

	// decimal split of all three rows, handed over as one beat
	logic      dig_valid;
	logic      dig_stall;
	dig_item_t dig;

	// pipeline: divide by 1000, 100 and 10 through reciprocal multiplies,
	// each product registered before it is used
	tss_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	// serialiser: holds one set of digits and plays out the twelve beats
	// in the order 4,3,2,1,8,7,6,5,12,11,10,9; the next set is taken as the
	// final beat leaves, so the split pipeline keeps filling meanwhile
	tss_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.scan       (scan)
	);

endmodule
